@@ rtl/crp_pkg.sv @@
// crp_pkg: shared types and constants for the cell reference parser.
// No dependencies; every other file of the block imports it.
package crp_pkg;

    // Default result widths, handed to the top-level parameters
    localparam int DEF_ROW_WIDTH    = 20;
    localparam int DEF_COLUMN_WIDTH = 14;

    // Configuration port
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 21;
    localparam int MAX_ROW_W      = 21;
    localparam int MAX_COLUMN_W   = 15;

    localparam logic [MAX_ROW_W-1:0]    MAX_ROW_RESET    = 21'd1048576;
    localparam logic [MAX_COLUMN_W-1:0] MAX_COLUMN_RESET = 15'd16384;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_ROW    = 2'd0,
        REG_MAX_COLUMN = 2'd1
    } cfg_reg_t;

    // Character classes
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam int COLUMN_RADIX = 26;
    localparam int ROW_RADIX    = 10;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_LETTERS = 2'd1,
        PH_DIGITS  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_LETTERS = 3'd1,
        ST_NO_DIGITS  = 3'd2,
        ST_BAD_CHAR   = 3'd3,
        ST_ROW_ZERO   = 3'd4,
        ST_RANGE      = 3'd5
    } status_t;

    // Programmed limits, from the register block to the step logic
    typedef struct packed {
        logic [MAX_ROW_W-1:0]    max_row;
        logic [MAX_COLUMN_W-1:0] max_column;
    } limits_t;

endpackage

@@ rtl/crp_if.sv @@
// crp_if: valid/ready channel interfaces of the cell reference parser.
// Depends on crp_pkg for the configuration and result widths.

interface crp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface crp_result_if import crp_pkg::*; #(
    parameter int ROW_WIDTH    = DEF_ROW_WIDTH,
    parameter int COLUMN_WIDTH = DEF_COLUMN_WIDTH
);
    logic                    valid;
    logic                    ready;
    logic [2:0]              status;
    logic [ROW_WIDTH-1:0]    row_index;
    logic [COLUMN_WIDTH-1:0] column_index;

    modport source (output valid, output status, output row_index,
                    output column_index, input ready);
    modport sink   (input valid, input status, input row_index,
                    input column_index, output ready);
endinterface

interface crp_cfg_if import crp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/cell_reference_parser_core.sv @@
// cell_reference_parser_core: top level of the A1-style cell reference parser.
// Depends on crp_pkg, crp_if, crp_cfg_regs and crp_step.
//
//  Channel   Dir   Payload                              Transaction
//  -------   ---   ----------------------------------   -----------------------------
//  chars     in    char_code[7:0], is_last              one character of a reference
//  results   out   status[2:0], row_index, column_index one parsed reference
//  cfg       in    index[1:0], data[20:0]               one limit register write
//
// Throughput is one character per cycle unless a last character waits on a full
// result slot. A character is captured in the input register, then the step logic
// updates the parse state and, on the last character, loads the result register.
// Reset (rst_n, async, low) returns to the start of a reference with default limits.
// A stalled result only blocks the next last character; other characters keep
// flowing and the input register holds a waiting last character until the slot frees.
module cell_reference_parser_core
    import crp_pkg::*;
#(
    parameter int ROW_WIDTH    = DEF_ROW_WIDTH,
    parameter int COLUMN_WIDTH = DEF_COLUMN_WIDTH
)(
    input  logic           clk,
    input  logic           rst_n,
    crp_char_if.sink       chars,
    crp_result_if.source   results,
    crp_cfg_if.sink        cfg
);

    // Configuration registers
    limits_t limits;

    crp_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    // Input register
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    // Parse state
    phase_t                phase_reg;
    logic [COLUMN_WIDTH:0] col_acc_reg;
    logic [ROW_WIDTH:0]    row_acc_reg;
    status_t               err_reg;

    // Result register
    logic                    out_valid_reg;
    status_t                 status_reg;
    logic [ROW_WIDTH-1:0]    row_index_reg;
    logic [COLUMN_WIDTH-1:0] column_index_reg;

    // Step outputs
    phase_t                  phase_next;
    logic [COLUMN_WIDTH:0]   col_acc_next;
    logic [ROW_WIDTH:0]      row_acc_next;
    status_t                 err_next;
    status_t                 res_status;
    logic [ROW_WIDTH-1:0]    res_row;
    logic [COLUMN_WIDTH-1:0] res_column;

    logic advance;
    logic in_take;
    logic out_take;

    crp_step #(
        .ROW_WIDTH    (ROW_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_step (
        .char_code    (char_reg),
        .phase        (phase_reg),
        .col_acc      (col_acc_reg),
        .row_acc      (row_acc_reg),
        .err          (err_reg),
        .limits       (limits),
        .phase_next   (phase_next),
        .col_acc_next (col_acc_next),
        .row_acc_next (row_acc_next),
        .err_next     (err_next),
        .res_status   (res_status),
        .res_row      (res_row),
        .res_column   (res_column)
    );

    // A held character moves on unless it ends a reference and the result
    // slot is full and not being drained this cycle.
    assign out_take    = out_valid_reg && results.ready;
    assign advance     = in_valid_reg && (!last_reg || !out_valid_reg || results.ready);
    assign chars.ready = !in_valid_reg || advance;
    assign in_take     = chars.valid && chars.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            col_acc_reg   <= '0;
            row_acc_reg   <= '0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                if (last_reg)
                begin
                    // Reference complete: back to a clean start
                    phase_reg   <= PH_START;
                    col_acc_reg <= '0;
                    row_acc_reg <= '0;
                    err_reg     <= ST_OK;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    col_acc_reg <= col_acc_next;
                    row_acc_reg <= row_acc_next;
                    err_reg     <= err_next;
                end
            end

            if (advance && last_reg)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= chars.char_code;
            last_reg <= chars.is_last;
        end
        if (advance && last_reg)
        begin
            status_reg       <= res_status;
            row_index_reg    <= res_row;
            column_index_reg <= res_column;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.status       = status_reg;
    assign results.row_index    = row_index_reg;
    assign results.column_index = column_index_reg;

    // Error results carry zero indexes
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_OK)
        |-> (row_index_reg == '0) && (column_index_reg == '0))
        else $error("error result with nonzero index");

    // An ok row lies within the programmed limit
    a_row_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_OK)
        |-> (64'(row_index_reg) < 64'(limits.max_row)))
        else $error("ok row beyond max_row");

    // Input stalls only behind a last character blocked by a full result slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !chars.ready |-> in_valid_reg && last_reg && out_valid_reg && !results.ready)
        else $error("input stalled without a blocked result");

    // Column accumulator never passes its saturation point
    a_col_sat: assert property (@(posedge clk) disable iff (!rst_n)
        col_acc_reg[COLUMN_WIDTH] |-> (col_acc_reg[COLUMN_WIDTH-1:1] == '0))
        else $error("column accumulator beyond saturation");

    // A finished reference leaves a clean parse state
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> (phase_reg == PH_START) && (err_reg == ST_OK)
                                && (row_acc_reg == '0))
        else $error("parse state not cleared after last character");

endmodule

@@ rtl/crp_cfg_regs.sv @@
// crp_cfg_regs: row and column limit registers behind the configuration channel.
// Depends on crp_pkg and crp_cfg_if.
module crp_cfg_regs
    import crp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    crp_cfg_if.sink      cfg,
    output limits_t      limits
);

    logic [MAX_ROW_W-1:0]    max_row_reg;
    logic [MAX_COLUMN_W-1:0] max_column_reg;

    // Always ready; writes to unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_row_reg    <= MAX_ROW_RESET;
            max_column_reg <= MAX_COLUMN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MAX_ROW:    max_row_reg    <= cfg.data[MAX_ROW_W-1:0];
                REG_MAX_COLUMN: max_column_reg <= cfg.data[MAX_COLUMN_W-1:0];
                default:        ;
            endcase
        end
    end

    assign limits.max_row    = max_row_reg;
    assign limits.max_column = max_column_reg;

endmodule

@@ rtl/crp_step.sv @@
// crp_step: per-character next-state logic and end-of-reference result.
// Depends on crp_pkg. Purely combinational, sits between the input and result registers.
module crp_step
    import crp_pkg::*;
#(
    parameter int ROW_WIDTH    = DEF_ROW_WIDTH,
    parameter int COLUMN_WIDTH = DEF_COLUMN_WIDTH
)(
    input  logic [7:0]              char_code,
    input  phase_t                  phase,
    input  logic [COLUMN_WIDTH:0]   col_acc,
    input  logic [ROW_WIDTH:0]      row_acc,
    input  status_t                 err,
    input  limits_t                 limits,
    output phase_t                  phase_next,
    output logic [COLUMN_WIDTH:0]   col_acc_next,
    output logic [ROW_WIDTH:0]      row_acc_next,
    output status_t                 err_next,
    output status_t                 res_status,
    output logic [ROW_WIDTH-1:0]    res_row,
    output logic [COLUMN_WIDTH-1:0] res_column
);

    localparam int CACC_W  = COLUMN_WIDTH + 1;
    localparam int RACC_W  = ROW_WIDTH + 1;
    localparam int CPROD_W = CACC_W + 5;
    localparam int RPROD_W = RACC_W + 4;
    localparam int CCMP_W  = (CACC_W > MAX_COLUMN_W) ? CACC_W : MAX_COLUMN_W;
    localparam int RCMP_W  = (RACC_W > MAX_ROW_W) ? RACC_W : MAX_ROW_W;

    // Saturation point: one above the largest representable 1-based value
    localparam logic [CACC_W-1:0] COL_CAP = {1'b1, {(COLUMN_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [RACC_W-1:0] ROW_CAP = {1'b1, {(ROW_WIDTH-1){1'b0}}, 1'b1};

    logic                is_upper;
    logic                is_lower;
    logic                is_letter;
    logic                is_digit;
    logic [4:0]          letter_val;
    logic [3:0]          digit_val;
    logic [CPROD_W-1:0]  col_prod;
    logic [RPROD_W-1:0]  row_prod;
    logic [CACC_W-1:0]   col_sat;
    logic [RACC_W-1:0]   row_sat;
    logic                col_over;
    logic                row_over;

    always_comb
    begin
        is_upper  = char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
        is_lower  = char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
        is_letter = is_upper || is_lower;
        is_digit  = char_code inside {[CHAR_ZERO:CHAR_NINE]};

        letter_val = is_upper ? 5'(char_code - CHAR_UPPER_A + 8'd1)
                              : 5'(char_code - CHAR_LOWER_A + 8'd1);
        digit_val  = 4'(char_code - CHAR_ZERO);

        // Bijective base-26 column, decimal row, both saturating
        col_prod = CPROD_W'(col_acc) * CPROD_W'(COLUMN_RADIX) + CPROD_W'(letter_val);
        row_prod = RPROD_W'(row_acc) * RPROD_W'(ROW_RADIX) + RPROD_W'(digit_val);
        col_sat  = (col_prod > CPROD_W'(COL_CAP)) ? COL_CAP : col_prod[CACC_W-1:0];
        row_sat  = (row_prod > RPROD_W'(ROW_CAP)) ? ROW_CAP : row_prod[RACC_W-1:0];

        phase_next   = phase;
        col_acc_next = col_acc;
        row_acc_next = row_acc;
        err_next     = err;

        if (is_letter)
        begin
            if (phase == PH_DIGITS)
            begin
                if (err == ST_OK)
                    err_next = ST_BAD_CHAR;
            end
            else
            begin
                col_acc_next = col_sat;
                phase_next   = PH_LETTERS;
            end
        end
        else if (is_digit)
        begin
            if (phase == PH_START)
            begin
                if (err == ST_OK)
                    err_next = ST_NO_LETTERS;
            end
            else
            begin
                row_acc_next = row_sat;
                phase_next   = PH_DIGITS;
            end
        end
        else if (err == ST_OK)
        begin
            err_next = ST_BAD_CHAR;
        end

        // x > min(limit, 2^W) is x > limit or x > 2^W
        col_over = (col_acc_next[COLUMN_WIDTH] && (|col_acc_next[COLUMN_WIDTH-1:0]))
                || (CCMP_W'(col_acc_next) > CCMP_W'(limits.max_column));
        row_over = (row_acc_next[ROW_WIDTH] && (|row_acc_next[ROW_WIDTH-1:0]))
                || (RCMP_W'(row_acc_next) > RCMP_W'(limits.max_row));

        res_row    = '0;
        res_column = '0;
        if (err_next != ST_OK)
            res_status = err_next;
        else if (phase_next != PH_DIGITS)
            res_status = ST_NO_DIGITS;
        else if (row_acc_next == '0)
            res_status = ST_ROW_ZERO;
        else if (row_over || col_over)
            res_status = ST_RANGE;
        else
        begin
            res_status = ST_OK;
            res_row    = ROW_WIDTH'(row_acc_next - RACC_W'(1));
            res_column = COLUMN_WIDTH'(col_acc_next - CACC_W'(1));
        end
    end

endmodule

@@ verif/crp_parse_checker.sv @@
// crp_parse_checker: watches the char, result and cfg channels of the cell
// reference parser, predicts each parsed reference and compares it with the DUT.
// Depends on crp_pkg and the channel interfaces in crp_if.
module crp_parse_checker
    import crp_pkg::*;
#(
    parameter int ROW_WIDTH    = DEF_ROW_WIDTH,
    parameter int COLUMN_WIDTH = DEF_COLUMN_WIDTH
)(
    input  logic  clk,
    input  logic  rst_n,
    crp_char_if   chars,
    crp_result_if results,
    crp_cfg_if    cfg,
    output int    refs_outstanding,
    output int    mismatches
);

    localparam logic [63:0] ROW_SPAN    = 64'd1 << ROW_WIDTH;
    localparam logic [63:0] COLUMN_SPAN = 64'd1 << COLUMN_WIDTH;
    // accumulators stop one above the widest limit, so overflow stays out of range
    localparam logic [63:0] ROW_CEIL    = ROW_SPAN + 64'd1;
    localparam logic [63:0] COLUMN_CEIL = COLUMN_SPAN + 64'd1;

    typedef struct {
        status_t                 status;
        logic [ROW_WIDTH-1:0]    row_index;
        logic [COLUMN_WIDTH-1:0] column_index;
    } parsed_ref_t;

    parsed_ref_t             expected_refs[$];
    logic [MAX_ROW_W-1:0]    max_row;
    logic [MAX_COLUMN_W-1:0] max_column;
    phase_t                  phase;
    logic [COLUMN_WIDTH:0]   column_acc;
    logic [ROW_WIDTH:0]      row_acc;
    status_t                 first_error;
    int                      errors;

    function automatic logic [63:0] clamp_limit(input logic [63:0] value,
                                                input logic [63:0] span);
        return (value < span) ? value : span;
    endfunction

    function automatic void keep_first_error(input status_t code);
        if (first_error == ST_OK)
            first_error = code;
    endfunction

    function automatic void advance_parse(input logic [7:0] code, input logic last);
        logic [4:0]  letter;
        logic [63:0] grown;
        parsed_ref_t outcome;
        letter = '0;
        if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z)
            letter = 5'(code - CHAR_UPPER_A) + 5'd1;
        else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z)
            letter = 5'(code - CHAR_LOWER_A) + 5'd1;

        if (letter != '0)
        begin
            if (phase == PH_DIGITS)
                keep_first_error(ST_BAD_CHAR);
            else
            begin
                grown = 64'(column_acc) * 64'(COLUMN_RADIX) + 64'(letter);
                column_acc = (COLUMN_WIDTH+1)'((grown > COLUMN_CEIL) ? COLUMN_CEIL : grown);
                phase = PH_LETTERS;
            end
        end
        else if (code >= CHAR_ZERO && code <= CHAR_NINE)
        begin
            if (phase == PH_START)
                keep_first_error(ST_NO_LETTERS);
            else
            begin
                grown = 64'(row_acc) * 64'(ROW_RADIX) + 64'(code - CHAR_ZERO);
                row_acc = (ROW_WIDTH+1)'((grown > ROW_CEIL) ? ROW_CEIL : grown);
                phase = PH_DIGITS;
            end
        end
        else
            keep_first_error(ST_BAD_CHAR);

        if (last)
        begin
            outcome.row_index    = '0;
            outcome.column_index = '0;
            if (first_error != ST_OK)
                outcome.status = first_error;
            else if (phase != PH_DIGITS)
                outcome.status = ST_NO_DIGITS;
            else if (row_acc == '0)
                outcome.status = ST_ROW_ZERO;
            else if (64'(row_acc) > clamp_limit(64'(max_row), ROW_SPAN) ||
                     64'(column_acc) > clamp_limit(64'(max_column), COLUMN_SPAN))
                outcome.status = ST_RANGE;
            else
            begin
                outcome.status       = ST_OK;
                outcome.row_index    = ROW_WIDTH'(row_acc - 1'b1);
                outcome.column_index = COLUMN_WIDTH'(column_acc - 1'b1);
            end
            expected_refs.push_back(outcome);
            phase       = PH_START;
            column_acc  = '0;
            row_acc     = '0;
            first_error = ST_OK;
        end
    endfunction

    function automatic void check_result();
        parsed_ref_t want;
        logic        bad;
        if (expected_refs.size() == 0)
        begin
            $display("%0t: unexpected result: status %0d row %0d column %0d",
                     $time, results.status, results.row_index, results.column_index);
            errors++;
            return;
        end
        want = expected_refs.pop_front();
        bad  = 1'b0;
        if (results.status !== want.status)
        begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, results.status);
            bad = 1'b1;
        end
        if (results.row_index !== want.row_index)
        begin
            $display("%0t: row_index mismatch: expected %0d actual %0d",
                     $time, want.row_index, results.row_index);
            bad = 1'b1;
        end
        if (results.column_index !== want.column_index)
        begin
            $display("%0t: column_index mismatch: expected %0d actual %0d",
                     $time, want.column_index, results.column_index);
            bad = 1'b1;
        end
        if (bad)
            errors++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_row     = MAX_ROW_RESET;
            max_column  = MAX_COLUMN_RESET;
            phase       = PH_START;
            column_acc  = '0;
            row_acc     = '0;
            first_error = ST_OK;
            errors      = 0;
            expected_refs.delete();
            refs_outstanding <= 0;
            mismatches       <= 0;
        end
        else
        begin
            // drain before fill: a result never belongs to a char taken this cycle
            if (results.valid && results.ready)
                check_result();
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MAX_ROW:    max_row    = cfg.data[MAX_ROW_W-1:0];
                    REG_MAX_COLUMN: max_column = cfg.data[MAX_COLUMN_W-1:0];
                    default:        ;
                endcase
            end
            if (chars.valid && chars.ready)
                advance_parse(chars.char_code, chars.is_last);
            refs_outstanding <= expected_refs.size();
            mismatches       <= errors;
        end
    end

endmodule

@@ verif/tb_cell_reference_parser_core.sv @@
// tb_cell_reference_parser_core: stimulus and verdict for the cell reference parser.
// Depends on crp_pkg, crp_if, cell_reference_parser_core and crp_parse_checker.
module tb_cell_reference_parser_core;
    import crp_pkg::*;

    localparam int ROW_WIDTH    = DEF_ROW_WIDTH;
    localparam int COLUMN_WIDTH = DEF_COLUMN_WIDTH;

    // Run length guard
    localparam int CYCLE_LIMIT  = 500000;
    // Cycles to let the two-stage pipe settle before cfg writes and the verdict
    localparam int DRAIN_CYCLES = 8;
    // Chars per limit setting in the random part
    localparam int PHASE_CHARS  = 100;
    localparam int PHASE_COUNT  = 7;

    localparam longint unsigned ROW_SPAN    = 64'd1 << ROW_WIDTH;
    localparam longint unsigned COLUMN_SPAN = 64'd1 << COLUMN_WIDTH;

    // Register indexes past the end of the map; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    // Stray chars: space, signs and punctuation, and the upper half of the code space
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_HIGH  = 8'h80;

    typedef logic [7:0] text_t[$];

    logic clk;
    logic rst_n;
    int   refs_outstanding;
    int   mismatches;
    int   cycles     = 0;
    int   stall_left = 0;
    int   phase_chars;
    logic gaps_on;
    logic stalls_on;

    // Effective limits as currently programmed, used only to aim row/column values
    longint unsigned row_limit;
    longint unsigned column_limit;

    crp_char_if chars();
    crp_result_if #(.ROW_WIDTH(ROW_WIDTH), .COLUMN_WIDTH(COLUMN_WIDTH)) results();
    crp_cfg_if cfg();

    cell_reference_parser_core #(
        .ROW_WIDTH    (ROW_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results),
        .cfg     (cfg)
    );

    crp_parse_checker #(
        .ROW_WIDTH    (ROW_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) parse_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .chars            (chars),
        .results          (results),
        .cfg              (cfg),
        .refs_outstanding (refs_outstanding),
        .mismatches       (mismatches)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly short idles, now and then a long one
    function automatic int gap_length();
        return ($urandom_range(0, 99) < 85) ? int'($urandom_range(1, 3))
                                            : int'($urandom_range(8, 40));
    endfunction

    // Result backpressure. With stalls off the sink takes every transaction at once.
    always @(posedge clk)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            results.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 99) < 30)
        begin
            results.ready <= 1'b0;
            stall_left    <= gap_length() - 1;
        end
        else
            results.ready <= 1'b1;
    end

    // One char transaction. Valid stays high across back-to-back chars; it only
    // drops for an idle gap, so it never gets two updates in one time step.
    task automatic send_char(input logic [7:0] code, input logic last);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 35) ? gap_length() : 0;
        if (gap > 0)
        begin
            chars.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_code <= code;
        chars.is_last   <= last;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        phase_chars++;
    endtask

    task automatic send_reference(input text_t text);
        int i;
        // about a quarter of the references go through with no idles at all
        gaps_on = ($urandom_range(0, 3) != 0);
        for (i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    function automatic text_t spell(input string s);
        text_t text;
        int    i;
        for (i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        return text;
    endfunction

    // Column number in bijective base 26, each letter upper or lower case at random
    function automatic void append_column(ref text_t text, input longint unsigned n);
        text_t           letters;
        longint unsigned v;
        v = n;
        while (v != 0)
        begin
            v = v - 1;
            letters.push_front((($urandom_range(0, 3) == 0) ? CHAR_LOWER_A : CHAR_UPPER_A)
                               + 8'(v % COLUMN_RADIX));
            v = v / COLUMN_RADIX;
        end
        foreach (letters[i])
            text.push_back(letters[i]);
    endfunction

    function automatic void append_row(ref text_t text, input longint unsigned n,
                                       input int zeros);
        text_t           digits;
        longint unsigned v;
        v = n;
        do
        begin
            digits.push_front(CHAR_ZERO + 8'(v % ROW_RADIX));
            v = v / ROW_RADIX;
        end
        while (v != 0);
        repeat (zeros) text.push_back(CHAR_ZERO);
        foreach (digits[i])
            text.push_back(digits[i]);
    endfunction

    // Spread values over small numbers, the full span, the edge of the programmed
    // limit, the edge of the span, and far past it so the accumulators saturate.
    function automatic longint unsigned pick_count(input longint unsigned limit,
                                                   input longint unsigned span,
                                                   input longint unsigned huge);
        longint unsigned base;
        base = (limit > 2) ? limit - 2 : 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(1, 30);
            4, 5:       return $urandom_range(1, 32'(span));
            6, 7:       return base + $urandom_range(0, 4);
            8:          return span - 1 + $urandom_range(0, 3);
            default:    return $urandom_range(32'(span) + 1, 32'(huge));
        endcase
    endfunction

    // Mostly well-formed references with random content; the rest are noise,
    // misplaced digits, trailing text, stray chars, missing rows and zero rows.
    function automatic text_t random_reference();
        text_t text;
        int    kind;
        int    spot;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            append_column(text, pick_count(column_limit, COLUMN_SPAN, 12000000));
            append_row(text, pick_count(row_limit, ROW_SPAN, 32'hFFFF_FFFF),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
        end
        else if (kind < 76)
        begin
            repeat ($urandom_range(1, 5)) text.push_back(8'($urandom));
        end
        else if (kind < 82)
        begin
            // row before any column letter
            append_row(text, $urandom_range(0, 999), 0);
            if ($urandom_range(0, 1) == 1)
                append_column(text, $urandom_range(1, 800));
        end
        else if (kind < 88)
        begin
            // letters trailing the row
            append_column(text, $urandom_range(1, 800));
            append_row(text, $urandom_range(1, 999), 0);
            append_column(text, $urandom_range(1, 30));
        end
        else if (kind < 94)
        begin
            append_column(text, $urandom_range(1, 800));
            append_row(text, $urandom_range(1, 9999), 0);
            spot = $urandom_range(0, text.size());
            case ($urandom_range(0, 2))
                0:       text.insert(spot, 8'($urandom_range(CHAR_SPACE, CHAR_SLASH)));
                1:       text.insert(spot, CHAR_HIGH | 8'($urandom));
                default: text.insert(spot, 8'($urandom));
            endcase
        end
        else if (kind < 97)
        begin
            append_column(text, pick_count(column_limit, COLUMN_SPAN, 12000000));
        end
        else
        begin
            append_column(text, $urandom_range(1, 800));
            repeat ($urandom_range(1, 3)) text.push_back(CHAR_ZERO);
        end
        return text;
    endfunction

    // Quiesce: drop valid, wait for every predicted reference to come back,
    // then wait out DRAIN_CYCLES for chars that make no result.
    task automatic wait_idle();
        chars.valid <= 1'b0;
        @(posedge clk);
        while (refs_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One cfg transaction; valid is left high so back-to-back writes need no toggle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    task automatic set_limits(input logic [MAX_ROW_W-1:0] row_max,
                              input logic [MAX_COLUMN_W-1:0] column_max);
        wait_idle();
        write_reg(REG_MAX_ROW, CFG_DATA_W'(row_max));
        // data bits above the column register carry junk and must be dropped
        write_reg(REG_MAX_COLUMN,
                  {(CFG_DATA_W-MAX_COLUMN_W)'($urandom), column_max});
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  CFG_DATA_W'($urandom));
        cfg.valid <= 1'b0;
        row_limit    = (row_max < ROW_SPAN) ? row_max : ROW_SPAN;
        column_limit = (column_max < COLUMN_SPAN) ? column_max : COLUMN_SPAN;
    endtask

    initial
    begin
        int p;

        clk             = 1'b0;
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.char_code = '0;
        chars.is_last   = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        gaps_on         = 1'b1;
        stalls_on       = 1'b1;
        phase_chars     = 0;
        row_limit       = (MAX_ROW_RESET < ROW_SPAN) ? MAX_ROW_RESET : ROW_SPAN;
        column_limit    = (MAX_COLUMN_RESET < COLUMN_SPAN) ? MAX_COLUMN_RESET : COLUMN_SPAN;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed references under the reset limits
        send_reference(spell("A1"));        // smallest cell
        send_reference(spell("a0"));        // row zero, lower case column
        send_reference(spell("7"));         // digit with no letters
        send_reference(spell("Q"));         // letters only, no row
        send_reference(spell("B2c"));       // letter trailing the row
        send_reference(spell("C007"));      // leading zeros are fine
        send_reference(spell("XFE9"));      // one column past the limit
        send_reference(spell("1+"));        // two errors, the first one wins
        send_char(8'hFF, 1'b1);             // lone char from the upper half
        send_reference(spell("z1048577"));  // one row past the limit

        // Random part, one limit setting per phase: reset values, the minimum,
        // all ones (capped by the result width), zero, small, random, span - 1.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       ;
                1:       set_limits(MAX_ROW_W'(1), MAX_COLUMN_W'(1));
                2:       set_limits('1, '1);
                3:       set_limits('0, '0);
                4:       set_limits(MAX_ROW_W'($urandom_range(1, 200)),
                                    MAX_COLUMN_W'($urandom_range(1, 60)));
                5:       set_limits(MAX_ROW_W'($urandom), MAX_COLUMN_W'($urandom));
                default: set_limits(MAX_ROW_W'(ROW_SPAN - 1), MAX_COLUMN_W'(COLUMN_SPAN - 1));
            endcase
            // every third phase runs the result side without backpressure
            stalls_on   <= (p % 3 != 2);
            phase_chars  = 0;
            while (phase_chars < PHASE_CHARS)
                send_reference(random_reference());
        end

        wait_idle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/crp_pkg.sv
rtl/crp_if.sv
rtl/crp_cfg_regs.sv
rtl/crp_step.sv
rtl/cell_reference_parser_core.sv
verif/crp_parse_checker.sv
verif/tb_cell_reference_parser_core.sv
